### hw/rtl/sks_pkg.sv
package sks_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 64;
	localparam int KEY_FIELD_BITS = 64;
	localparam int ENTRY_BITS = 5;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = (CNT_W > ENTRY_BITS) ? CNT_W : ENTRY_BITS;

	typedef enum logic [1:0] {
		KIND_CONTAINS = 2'd0,
		KIND_INSERT   = 2'd1,
		KIND_ERASE    = 2'd2,
		KIND_CLEAR    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_EWR,
		ST_RESP
	} state_t;

	typedef struct packed {
		kind_t                     kind;
		logic [KEY_FIELD_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic                  dropped_full;
		logic [ENTRY_BITS-1:0] entry_count;
		logic                  found;
	} res_t;

endpackage

### hw/rtl/sks_ctrl.sv
module sks_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sks_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output sks_pkg::res_t res
);

	logic [sks_pkg::KEY_BITS-1:0] mem [sks_pkg::CAPACITY];

	sks_pkg::state_t state_q, state_d;
	logic [sks_pkg::CNT_W-1:0] count_q, count_d;
	logic [sks_pkg::CNT_W-1:0] idx_q, idx_d;
	logic                      vld_s1, vld_d;
	logic [sks_pkg::CNT_W-1:0] slot_s1;
	logic [sks_pkg::IDX_W-1:0] slot_q, slot_d;
	logic                      found_q, found_d;
	logic                      dropped_q, dropped_d;
	sks_pkg::kind_t            kind_q, kind_d;
	logic [sks_pkg::KEY_BITS-1:0] key_q, key_d;
	logic [sks_pkg::KEY_BITS-1:0] rdata_s1;

	logic [sks_pkg::IDX_W-1:0]    rd_addr;
	logic                         we;
	logic [sks_pkg::IDX_W-1:0]    wr_addr;
	logic [sks_pkg::KEY_BITS-1:0] wr_data;
	logic                         rd_en;
	logic                         hit;
	logic [sks_pkg::CNT_W-1:0]    cnt_m1;
	logic [sks_pkg::EXT_W-1:0]    count_ext;

	assign rd_en     = idx_q < count_q;
	assign hit       = vld_s1 && (rdata_s1 == key_q);
	assign cnt_m1    = count_q - 1'b1;
	assign count_ext = sks_pkg::EXT_W'(count_q);

	assign res.found        = found_q;
	assign res.dropped_full = dropped_q;
	assign res.entry_count  = count_ext[sks_pkg::ENTRY_BITS-1:0];

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		vld_d     = 1'b0;
		slot_d    = slot_q;
		found_d   = found_q;
		dropped_d = dropped_q;
		kind_d    = kind_q;
		key_d     = key_q;
		rd_addr   = idx_q[sks_pkg::IDX_W-1:0];
		we        = 1'b0;
		wr_addr   = count_q[sks_pkg::IDX_W-1:0];
		wr_data   = key_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			sks_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					kind_d    = req.kind;
					key_d     = req.key[sks_pkg::KEY_BITS-1:0];
					idx_d     = '0;
					found_d   = 1'b0;
					dropped_d = 1'b0;
					if (req.kind == sks_pkg::KIND_CLEAR) begin
						count_d = '0;
						state_d = sks_pkg::ST_RESP;
					end else begin
						state_d = sks_pkg::ST_SCAN;
					end
				end
			end
			sks_pkg::ST_SCAN: begin
				if (hit) begin
					found_d = 1'b1;
					slot_d  = slot_s1[sks_pkg::IDX_W-1:0];
					state_d = sks_pkg::ST_ACT;
				end else if (rd_en) begin
					idx_d = idx_q + 1'b1;
					vld_d = 1'b1;
				end else begin
					state_d = sks_pkg::ST_ACT;
				end
			end
			sks_pkg::ST_ACT: begin
				rd_addr = cnt_m1[sks_pkg::IDX_W-1:0];
				state_d = sks_pkg::ST_RESP;
				case (kind_q)
					sks_pkg::KIND_INSERT: begin
						if (!found_q) begin
							if (count_q < sks_pkg::CNT_W'(sks_pkg::CAPACITY)) begin
								we      = 1'b1;
								count_d = count_q + 1'b1;
							end else begin
								dropped_d = 1'b1;
							end
						end
					end
					sks_pkg::KIND_ERASE: begin
						if (found_q) begin
							state_d = sks_pkg::ST_EWR;
						end
					end
					default: begin
					end
				endcase
			end
			sks_pkg::ST_EWR: begin
				we      = 1'b1;
				wr_addr = slot_q;
				wr_data = rdata_s1;
				count_d = cnt_m1;
				state_d = sks_pkg::ST_RESP;
			end
			sks_pkg::ST_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = sks_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sks_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sks_pkg::ST_IDLE;
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			vld_s1  <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		slot_s1   <= idx_q;
		slot_q    <= slot_d;
		found_q   <= found_d;
		dropped_q <= dropped_d;
		kind_q    <= kind_d;
		key_q     <= key_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sks_pkg::CNT_W'(sks_pkg::CAPACITY))
		else $error("held count exceeds capacity");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sks_pkg::ST_SCAN && vld_s1) |-> (slot_s1 < count_q))
		else $error("scan compared an entry beyond the held count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.dropped_full) |->
		(count_q == sks_pkg::CNT_W'(sks_pkg::CAPACITY) && !res.found))
		else $error("insert dropped while table not full or key present");

	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sks_pkg::ST_IDLE && !req_valid) |=> $stable(count_q))
		else $error("held count changed with no transaction");
`endif

endmodule

### hw/rtl/small_key_set_unit.sv
// Set of distinct keys held unsorted in a table of sks_pkg::CAPACITY entries.
// Requests arrive on the s_* stream: tuser carries the operation (contains,
// insert, erase, clear) and tdata the key. Every request yields exactly one
// response transaction on the m_* stream with the found flag, the count of
// keys held afterward and the dropped flag for an insert into a full table.
// A request is scanned against the held entries one table read per cycle
// through the single memory read port. With the key absent every held
// entry is scanned; a hit ends the scan at that slot. The request then
// passes the act state, and an erase that hits adds a state that copies
// the last entry into the freed slot, before the response state hands the
// result to the response register. A clear goes straight from idle to the
// response state. Requests are processed one at a time: the next one is
// accepted only once the unit is back in idle.
// The response register lets the next request be accepted while a response
// waits; if the receiver stalls, the unit finishes that request and then
// holds until the register frees. Reset empties the set at once; table
// contents need no clearing since only entries below the count are read.
module small_key_set_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // key[63:0]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // found[0], entry_count[5:1], dropped_full[6], zero[7]
);

	sks_pkg::req_t req;
	sks_pkg::res_t res;
	logic          res_valid;
	logic          res_ready;
	logic          m_tvalid_q;
	sks_pkg::res_t res_q;

	assign req.kind = sks_pkg::kind_t'(s_tuser);
	assign req.key  = s_tdata;

	assign res_ready = !m_tvalid_q || m_tready;

	sks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, res_q.dropped_full, res_q.entry_count, res_q.found};

endmodule

### tb/sv/tb_small_key_set_unit.sv
module tb_small_key_set_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sks_pkg::*;

	localparam logic [63:0] KEY_MASK = (KEY_BITS >= 64) ? '1 : ((64'd1 << KEY_BITS) - 64'd1);
	localparam int RANDOM_ITEMS = 1125;
	localparam int POOL_SIZE = 20;

	class key_set_checker;
		logic [63:0] slots[CAPACITY];
		int          held;
		res_t        expected_q[$];
		int          errors;

		function new();
			held = 0;
			errors = 0;
			foreach (slots[i]) slots[i] = '0;
		endfunction

		function void note_request(kind_t kind, logic [63:0] key);
			res_t        r;
			int          hit;
			logic [63:0] k;
			r = '0;
			hit = -1;
			k = key & KEY_MASK;
			if (kind == KIND_CLEAR) begin
				held = 0;
			end else begin
				for (int i = 0; i < held; i++) begin
					if (hit < 0 && slots[i] == k) begin
						hit = i;
					end
				end
				r.found = (hit >= 0);
				if (kind == KIND_INSERT && hit < 0) begin
					if (held < CAPACITY) begin
						slots[held] = k;
						held++;
					end else begin
						r.dropped_full = 1'b1;
					end
				end else if (kind == KIND_ERASE && hit >= 0) begin
					slots[hit] = slots[held - 1];
					held--;
				end
			end
			r.entry_count = held[ENTRY_BITS-1:0];
			expected_q.push_back(r);
		endfunction

		function void check_response(logic [7:0] bits);
			res_t want;
			res_t got;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response, actual %h", $time, bits);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			got = res_t'(bits[6:0]);
			if (got.found !== want.found) begin
				$display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
				errors++;
			end
			if (got.entry_count !== want.entry_count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time,
					want.entry_count, got.entry_count);
				errors++;
			end
			if (got.dropped_full !== want.dropped_full) begin
				$display("%0t: dropped_full expected %0d actual %0d", $time,
					want.dropped_full, got.dropped_full);
				errors++;
			end
			if (bits[7] !== 1'b0) begin
				$display("%0t: pad bit expected 0 actual %b", $time, bits[7]);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [63:0] held_key(int idx);
			return slots[idx];
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = KIND_CONTAINS;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	key_set_checker sb = new();
	logic [63:0]    key_pool[POOL_SIZE];
	int             rx_cycle = 0;
	int             stall_left = 0;

	small_key_set_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("FAIL small_key_set_unit");
		$finish;
	end

	// The receiver alternates between always ready, random ready and long stall runs.
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 97) % 3)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left <= stall_left - 1;
				end else begin
					m_tready <= 1'b1;
					if ($urandom_range(0, 2) == 0) begin
						stall_left <= $urandom_range(1, 12);
					end
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_response(m_tdata);
		end
	end

	task automatic send_request(kind_t kind, logic [63:0] key);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(kind, key);
	endtask

	task automatic idle_for(int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain_responses();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] random_key();
		return {$urandom, $urandom};
	endfunction

	task automatic run_directed();
		send_request(KIND_CLEAR, '1);
		send_request(KIND_CONTAINS, '0);
		send_request(KIND_ERASE, '0);
		send_request(KIND_INSERT, '0);
		send_request(KIND_INSERT, '1);
		send_request(KIND_INSERT, '0);
		for (int i = 0; i < CAPACITY - 2; i++) begin
			send_request(KIND_INSERT, random_key());
		end
		send_request(KIND_INSERT, 64'h5555_aaaa_5555_aaaa);
		send_request(KIND_INSERT, '1);
		send_request(KIND_CONTAINS, '1);
		send_request(KIND_ERASE, '1);
		send_request(KIND_ERASE, '0);
		send_request(KIND_CLEAR, 64'h0123_4567_89ab_cdef);
	endtask

	task automatic run_random();
		int          sent;
		int          burst;
		int          pick;
		kind_t       kind;
		logic [63:0] key;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3) begin
					kind = KIND_CLEAR;
				end else if (pick < 42) begin
					kind = KIND_INSERT;
				end else if (pick < 72) begin
					kind = KIND_ERASE;
				end else begin
					kind = KIND_CONTAINS;
				end
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					key = random_key();
				end else if (pick < 40 && sb.held > 0) begin
					key = sb.held_key($urandom_range(0, sb.held - 1));
				end else begin
					key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				end
				send_request(kind, key);
				sent++;
				if (sent % 300 == 0) begin
					for (int p = 0; p < POOL_SIZE / 4; p++) begin
						key_pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
					end
				end
				if (sent % 250 == 0) begin
					drain_responses();
				end
			end
			if ((sent / 128) % 2 == 0) begin
				idle_for($urandom_range(0, 10));
			end
		end
	endtask

	initial begin
		foreach (key_pool[i]) key_pool[i] = random_key();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		drain_responses();
		run_random();
		drain_responses();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS small_key_set_unit");
		end else begin
			$display("FAIL small_key_set_unit");
		end
		$finish;
	end

endmodule
